// File: rtl/core/idac_pkg.sv
package idac_pkg;

  localparam int unsigned ValueWidthDefault = 32;
  localparam int unsigned CharWidth         = 8;

  localparam logic [CharWidth-1:0] DigitBase = 8'd48;
  localparam logic [CharWidth-1:0] MinusChar = 8'd45;

  // Per-cycle command for the BCD cell row
  typedef struct packed {
    logic clr;     // zero every digit
    logic dabble;  // add-3 correction, then shift one bit toward the top
    logic dshift;  // move every digit one cell toward the top
  } idac_ctrl_t;

endpackage

// File: rtl/core/signed_int_to_decimal_ascii.sv
// Flow: bit-serial double dabble over all VALUE_WIDTH bits through the digit cell row,
// then leading zeros are dropped one at a time (the final digit is always kept), then
// one character per cycle, while the output is not stalled, into the output register,
// with a minus sign first for a negative value.
// Throughput: one number at a time; a new number is accepted only after the last
// character of the previous one has been loaded into the output register.
// Reset: asynchronous active low; returns to idle with no word pending.
module signed_int_to_decimal_ascii
  import idac_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_axis_tdata_i,   // [VALUE_WIDTH-1:0] value
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [CharWidth-1:0]                m_axis_tdata_o,   // [7:0] ascii_char
  output logic                                m_axis_tlast_o    // last_char
);

  localparam int unsigned NumDigits = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned CntW      = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned LeftW     = $clog2(NumDigits + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSkip = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [LeftW-1:0]       left_q, left_d;
  logic                   neg_q, neg_d;
  logic                   out_valid_q, out_valid_d;
  logic [CharWidth-1:0]   out_data_q, out_data_d;
  logic                   out_last_q, out_last_d;

  logic [VALUE_WIDTH-1:0] raw;
  logic                   in_fire;
  logic                   out_free;
  idac_ctrl_t             ctrl;

  logic [NumDigits:0]     bit_chain;
  logic [3:0]             digit_chain [NumDigits+1];
  logic [3:0]             top_digit;

  assign raw      = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign top_digit = digit_chain[NumDigits];

  assign bit_chain[0]   = mag_q[VALUE_WIDTH-1];
  assign digit_chain[0] = 4'd0;

  for (genvar g = 0; g < NumDigits; g++) begin : g_cell
    idac_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .bit_i   (bit_chain[g]),
      .digit_i (digit_chain[g]),
      .bit_o   (bit_chain[g+1]),
      .digit_o (digit_chain[g+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    cnt_d       = cnt_q;
    left_d      = left_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    ctrl        = '0;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          neg_d   = raw[VALUE_WIDTH-1];
          mag_d   = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
          cnt_d   = CntW'(VALUE_WIDTH);
          ctrl.clr = 1'b1;
          state_d = StConv;
        end
      end
      StConv: begin
        ctrl.dabble = 1'b1;
        mag_d       = {mag_q[VALUE_WIDTH-2:0], 1'b0};
        cnt_d       = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          left_d  = LeftW'(NumDigits);
          state_d = StSkip;
        end
      end
      StSkip: begin
        // drop leading zeros, always keep the final digit
        if (top_digit == 4'd0 && left_q != LeftW'(1)) begin
          ctrl.dshift = 1'b1;
          left_d      = left_q - 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (neg_q) begin
            out_data_d = MinusChar;
            out_last_d = 1'b0;
            neg_d      = 1'b0;
          end else begin
            out_data_d  = DigitBase + {4'd0, top_digit};
            out_last_d  = (left_q == LeftW'(1));
            ctrl.dshift = 1'b1;
            left_d      = left_q - 1'b1;
            if (left_q == LeftW'(1)) begin
              state_d = StIdle;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      left_q      <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      left_q      <= left_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: rtl/core/idac_cell.sv
module idac_cell
  import idac_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  idac_ctrl_t ctrl_i,
  input  logic       bit_i,
  input  logic [3:0] digit_i,
  output logic       bit_o,
  output logic [3:0] digit_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  // Correct before the shift so the digit stays in 0..9 after doubling
  assign adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clr) begin
      digit_d = 4'd0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctrl_i.dshift) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign bit_o   = adj[3];
  assign digit_o = digit_q;

endmodule
